FILE: rtl/core/min_priority_queue_unsorted_macros.svh
// Assertion macros for the min priority queue checker.
`ifndef MIN_PRIORITY_QUEUE_UNSORTED_MACROS_SVH
`define MIN_PRIORITY_QUEUE_UNSORTED_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mpq_pkg.sv
// Package with operation and status codes and default sizing for the min priority queue.
package mpq_pkg;

	localparam int DEPTH_DEF = 128;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_PEEK   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

FILE: rtl/core/min_priority_queue_unsorted.sv
// Min priority queue over an unsorted store in insertion order, one shared scan and move datapath.
//
// Usage: drive func and value with start high while busy is low; the beat is taken at that
// edge. Every beat returns exactly one result, shown for one cycle with done high, and the
// receiver cannot stall it. Insert, a status-only answer (full, empty) and the unused
// selector finish without a scan: done is high in the cycle after the accepting edge. Peek
// reads every stored entry once through the single read port of the store, one per cycle.
// Delete adds a move pass over the entries after the minimum through the same port, one
// per cycle, unless the minimum is the last entry. busy drops in the cycle that done is
// high, so a new beat may be given then. The store needs no clearing after reset.
module min_priority_queue_unsorted
	import mpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	output logic [7:0]         occupancy
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;

	logic [31:0]   mem_q [DEPTH];

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic          op_del_q, op_del_d;
	logic          rd_vld_s1, rd_vld_d;
	logic [IW-1:0] rd_idx_s1;
	logic [31:0]   rd_data_s1;
	logic [31:0]   best_q;
	logic [IW-1:0] best_idx_q;
	logic          done_q;
	logic [31:0]   result_q;
	logic [1:0]    status_q;
	logic [7:0]    occ_q;

	logic          accept;
	logic          issue;
	logic          is_last;
	logic          take;
	logic [31:0]   min_val;
	logic [IW-1:0] min_idx;
	logic          fin;
	logic [31:0]   fin_val;
	logic [1:0]    fin_st;
	logic          we;
	logic [IW-1:0] wa;
	logic [31:0]   wd;

	assign accept  = start && !busy;
	assign issue   = ptr_q < cnt_q;
	assign is_last = rd_vld_s1 && (CW'(rd_idx_s1) == cnt_q - CW'(1));
	assign take    = (state_q == S_SCAN) && rd_vld_s1 &&
		((rd_idx_s1 == '0) || ($signed(rd_data_s1) < $signed(best_q)));
	assign min_val = take ? rd_data_s1 : best_q;
	assign min_idx = take ? rd_idx_s1 : best_idx_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		op_del_d = op_del_q;
		rd_vld_d = 1'b0;
		fin      = 1'b0;
		fin_val  = '0;
		fin_st   = ST_OK;
		we       = 1'b0;
		wa       = cnt_q[IW-1:0];
		wd       = value;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (func)
						OP_INSERT: begin
							fin = 1'b1;
							if (cnt_q == CW'(DEPTH)) begin
								fin_st = ST_FULL;
							end else begin
								we    = 1'b1;
								cnt_d = cnt_q + CW'(1);
							end
						end
						OP_DELETE, OP_PEEK: begin
							if (cnt_q == '0) begin
								fin    = 1'b1;
								fin_st = ST_EMPTY;
							end else begin
								state_d  = S_SCAN;
								ptr_d    = '0;
								op_del_d = (func == OP_DELETE);
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_vld_d = issue;
				if (issue) begin
					ptr_d = ptr_q + CW'(1);
				end
				if (is_last) begin
					rd_vld_d = 1'b0;
					if (!op_del_q) begin
						fin     = 1'b1;
						fin_val = min_val;
						state_d = S_IDLE;
					end else if (CW'(min_idx) == cnt_q - CW'(1)) begin
						fin     = 1'b1;
						fin_val = min_val;
						cnt_d   = cnt_q - CW'(1);
						state_d = S_IDLE;
					end else begin
						ptr_d   = CW'(min_idx) + CW'(1);
						state_d = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				rd_vld_d = issue;
				if (issue) begin
					ptr_d = ptr_q + CW'(1);
				end
				if (rd_vld_s1) begin
					we = 1'b1;
					wa = rd_idx_s1 - IW'(1);
					wd = rd_data_s1;
				end
				if (is_last) begin
					rd_vld_d = 1'b0;
					fin      = 1'b1;
					fin_val  = best_q;
					cnt_d    = cnt_q - CW'(1);
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_data_s1 <= mem_q[ptr_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			op_del_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			ptr_q     <= ptr_d;
			op_del_q  <= op_del_d;
			rd_vld_s1 <= rd_vld_d;
			done_q    <= fin;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[IW-1:0];
		if (take) begin
			best_q     <= min_val;
			best_idx_q <= min_idx;
		end
		if (fin) begin
			result_q <= fin_val;
			status_q <= fin_st;
			occ_q    <= 8'(cnt_d);
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule

FILE: rtl/core/mpq_checker.sv
// Port-level checker for the min priority queue, bound to the top level.
`include "min_priority_queue_unsorted_macros.svh"
module mpq_checker
	import mpq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] result_value,
	input logic [1:0]         status,
	input logic [7:0]         occupancy
);

	`MPQ_ASSERT_NOW(a_done_idle, done, !busy, "result beat while still busy")
	`MPQ_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted beat dropped")
	`MPQ_ASSERT_NOW(a_bad_zero, done && (status != ST_OK), result_value == 32'sd0,
		"nonzero value on failed operation")
	`MPQ_ASSERT_NOW(a_empty_occ, done && (status == ST_EMPTY), occupancy == 8'd0,
		"empty status with stored entries")

endmodule

bind min_priority_queue_unsorted mpq_checker u_mpq_checker (.*);
